// File: src/phase_distortion_shaper_unit_assert.svh
// ----------------------------------------------------------------------------
// Phase distortion shaper assertion macros
// Shared macros for the concurrent checks of the shaper.
// ----------------------------------------------------------------------------
`ifndef PHASE_DISTORTION_SHAPER_UNIT_ASSERT_SVH
`define PHASE_DISTORTION_SHAPER_UNIT_ASSERT_SVH

// A check that is switched off while reset is high.
`define PDS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A check that also holds across reset.
`define PDS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pds_pkg.sv
// ----------------------------------------------------------------------------
// Phase distortion shaper package
// Mode codes, default width and the control word that rides the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

  localparam int PHASE_BITS_DEF = 16;

  localparam logic [2:0] MODE_BEND_RIGHT = 3'd0;
  localparam logic [2:0] MODE_BEND_LEFT  = 3'd1;
  localparam logic [2:0] MODE_MIRRORED   = 3'd2;
  localparam logic [2:0] MODE_TWO_PEAKS  = 3'd3;
  localparam logic [2:0] MODE_STRETCH    = 3'd4;
  localparam logic [2:0] MODE_SYNC       = 3'd5;

  localparam logic [1:0] BASE_ZERO    = 2'd0;
  localparam logic [1:0] BASE_QUARTER = 2'd1;
  localparam logic [1:0] BASE_HALF    = 2'd2;
  localparam logic [1:0] BASE_THREE_Q = 2'd3;

  typedef struct packed {
    logic       bypass;
    logic [1:0] base_sel;
    logic [1:0] shift;
    logic       mir_lo;
    logic       mir_hi;
  } pds_ctrl_t;

endpackage

// File: src/pds_div_pipe.sv
// ----------------------------------------------------------------------------
// Phase distortion shaper divider pipeline
// Restoring division of num * 2^P by den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_div_pipe
  import pds_pkg::*;
#(
  parameter int P = PHASE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [P+1:0]   num,
  input  logic [P+1:0]   den,
  input  pds_ctrl_t      ctrl_in,
  input  logic [P-1:0]   byp_in,
  output logic           out_valid,
  output logic [P:0]     quot,
  output pds_ctrl_t      ctrl_out,
  output logic [P-1:0]   byp_out
);

  localparam int N = P + 1;

  logic            v    [N];
  logic [P+1:0]    rem  [N];
  logic [P+1:0]    dn   [N];
  logic [P:0]      q    [N];
  pds_ctrl_t       ctl  [N];
  logic [P-1:0]    byp  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [P+2:0] trial;
    logic [P+2:0] den_e;
    logic         ge;
    logic [P+2:0] diff;

    if (k == 0) begin : g_first
      assign trial = {1'b0, num};
      assign den_e = {1'b0, den};
    end else begin : g_rest
      assign trial = {rem[k-1], 1'b0};
      assign den_e = {1'b0, dn[k-1]};
    end

    assign ge   = (trial >= den_e);
    assign diff = ge ? (trial - den_e) : trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= diff[P+1:0];
        if (k == 0) begin
          dn[k]  <= den;
          q[k]   <= {{P{1'b0}}, ge};
          ctl[k] <= ctrl_in;
          byp[k] <= byp_in;
        end else begin
          dn[k]  <= dn[(k == 0) ? 0 : k-1];
          q[k]   <= {q[(k == 0) ? 0 : k-1][P-1:0], ge};
          ctl[k] <= ctl[(k == 0) ? 0 : k-1];
          byp[k] <= byp[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign out_valid = v[N-1];
  assign quot      = q[N-1];
  assign ctrl_out  = ctl[N-1];
  assign byp_out   = byp[N-1];

endmodule

// File: src/phase_distortion_shaper_unit.sv
// Each word passes the s1 and s2 registers, the divider stages and the output register in turn.
// Throughput: one word per cycle; the quotient is built one bit per stage.
// The output register holds a word until taken, and the whole pipeline stalls with it.
// Reset clears all valid bits and sets shape_mode to bend right.
// ----------------------------------------------------------------------------
// Phase distortion shaper
// Warps an oscillator phase by the piecewise-linear curve that shape_mode selects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "phase_distortion_shaper_unit_assert.svh"

module phase_distortion_shaper_unit
  import pds_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PHASE_BITS-1:0] phase_in,
  input  logic [PHASE_BITS:0]   amount,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PHASE_BITS-1:0] shaped_phase
);

  localparam int P = PHASE_BITS;
  localparam int W = P + 3;

  localparam logic [W-1:0] ONE_W  = {3'b001, {P{1'b0}}};
  localparam logic [W-1:0] TWO_W  = {3'b010, {P{1'b0}}};
  localparam logic [W-1:0] THR_W  = {3'b011, {P{1'b0}}};
  localparam logic [W-1:0] FOUR_W = {3'b100, {P{1'b0}}};
  localparam logic [P:0]   ONE_A  = {1'b1, {P{1'b0}}};
  localparam logic [P+1:0] MASK_R = {2'b00, {P{1'b1}}};

  logic [2:0] shape_mode;
  logic       adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= MODE_BEND_RIGHT;
    end else if (cfg_we) begin
      shape_mode <= cfg_wdata;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic         s1_valid;
  logic [P-1:0] s1_ph;
  logic [P:0]   s1_amt;
  logic [2:0]   s1_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ph   <= phase_in;
      s1_amt  <= (amount > ONE_A) ? ONE_A : amount;
      s1_mode <= shape_mode;
    end
  end

  logic [W-1:0]   ph_w, a_w, h2, xb, x4, x2;
  logic [W-1:0]   num_c, den_c;
  logic [P+3:0]   mult;
  logic [2*P+3:0] prod;
  pds_ctrl_t      ctrl_c;
  logic [P-1:0]   byp_c;

  assign ph_w = W'(s1_ph);
  assign a_w  = W'(s1_amt);
  assign x4   = ph_w << 2;
  assign x2   = ph_w << 1;
  assign mult = (P+4)'(ONE_W) + (P+4)'(a_w) * (P+4)'(12);
  assign prod = (2*P+4)'(s1_ph) * (2*P+4)'(mult);

  always_comb begin
    h2     = (s1_mode == MODE_BEND_RIGHT) ? (ONE_W + a_w) : (ONE_W - a_w);
    xb     = ph_w;
    num_c  = '0;
    den_c  = '0;
    ctrl_c = '0;
    byp_c  = s1_ph;
    case (s1_mode)
      MODE_BEND_RIGHT, MODE_BEND_LEFT, MODE_MIRRORED: begin
        if (s1_mode == MODE_MIRRORED) begin
          xb            = s1_ph[P-1] ? ((ONE_W - ph_w) << 1) : (ph_w << 1);
          ctrl_c.mir_hi = s1_ph[P-1];
          ctrl_c.mir_lo = !s1_ph[P-1];
        end
        if ((xb << 1) < h2) begin
          num_c = xb;
          den_c = h2;
        end else begin
          num_c           = (xb << 1) - h2;
          den_c           = TWO_W - h2;
          ctrl_c.base_sel = BASE_HALF;
          ctrl_c.shift    = 2'd1;
        end
      end
      MODE_TWO_PEAKS: begin
        if (x4 <= ONE_W - a_w) begin
          num_c        = x4;
          den_c        = ONE_W - a_w;
          ctrl_c.shift = 2'd2;
        end else if (x4 <= ONE_W + a_w) begin
          ctrl_c.base_sel = BASE_QUARTER;
        end else if (x4 <= THR_W - a_w) begin
          num_c           = x4 - (ONE_W + a_w);
          den_c           = TWO_W - (a_w << 1);
          ctrl_c.base_sel = BASE_QUARTER;
          ctrl_c.shift    = 2'd1;
        end else if (x4 <= THR_W + a_w) begin
          ctrl_c.base_sel = BASE_THREE_Q;
        end else begin
          num_c           = x4 - (THR_W + a_w);
          den_c           = FOUR_W - (THR_W + a_w);
          ctrl_c.base_sel = BASE_THREE_Q;
          ctrl_c.shift    = 2'd2;
        end
      end
      MODE_STRETCH: begin
        if (x2 <= ONE_W - a_w) begin
          num_c        = x2;
          den_c        = ONE_W - a_w;
          ctrl_c.shift = 2'd1;
        end else if (x2 <= ONE_W + a_w) begin
          ctrl_c.base_sel = BASE_HALF;
        end else begin
          num_c           = x2 - (ONE_W + a_w);
          den_c           = TWO_W - (ONE_W + a_w);
          ctrl_c.base_sel = BASE_HALF;
          ctrl_c.shift    = 2'd1;
        end
      end
      MODE_SYNC: begin
        ctrl_c.bypass = 1'b1;
        byp_c         = prod[2*P-1:P];
      end
      default: begin
        ctrl_c.bypass = 1'b1;
      end
    endcase
    if (den_c == '0) begin
      num_c = '0;
      den_c = W'(1);
    end
  end

  logic         s2_valid;
  logic [P+1:0] s2_num, s2_den;
  pds_ctrl_t    s2_ctrl;
  logic [P-1:0] s2_byp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_num  <= num_c[P+1:0];
      s2_den  <= den_c[P+1:0];
      s2_ctrl <= ctrl_c;
      s2_byp  <= byp_c;
    end
  end

  logic         div_valid;
  logic [P:0]   div_q;
  pds_ctrl_t    div_ctrl;
  logic [P-1:0] div_byp;

  pds_div_pipe #(.P(P)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s2_valid),
    .num       (s2_num),
    .den       (s2_den),
    .ctrl_in   (s2_ctrl),
    .byp_in    (s2_byp),
    .out_valid (div_valid),
    .quot      (div_q),
    .ctrl_out  (div_ctrl),
    .byp_out   (div_byp)
  );

  logic [P+1:0] qs, base_v, sum, r_c;

  always_comb begin
    qs = {1'b0, div_q} >> div_ctrl.shift;
    case (div_ctrl.base_sel)
      BASE_QUARTER: base_v = (P+2)'(ONE_W >> 2);
      BASE_HALF:    base_v = (P+2)'(ONE_W >> 1);
      BASE_THREE_Q: base_v = (P+2)'((ONE_W >> 1) + (ONE_W >> 2));
      default:      base_v = '0;
    endcase
    sum = base_v + qs;
    if (div_ctrl.bypass) begin
      r_c = (P+2)'(div_byp);
    end else if (div_ctrl.mir_hi) begin
      r_c = (P+2)'(ONE_W) - (sum >> 1);
    end else if (div_ctrl.mir_lo) begin
      r_c = sum >> 1;
    end else begin
      r_c = sum;
    end
    if (r_c > MASK_R) begin
      r_c = MASK_R;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shaped_phase <= r_c[P-1:0];
    end
  end

  `PDS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "Output word valid after reset")
  `PDS_ASSERT(a_amt_sat, clk, rst, s1_valid |-> (s1_amt <= ONE_A), "Amount not saturated")
  `PDS_ASSERT(a_quot_range, clk, rst, div_valid |-> (div_q <= ONE_A), "Quotient above one")
  `PDS_ASSERT(a_stall_hold, clk, rst, !adv |=> ($stable(s2_valid) && $stable(s2_num)), "Stall moved a word")

endmodule

// File: tb/phase_distortion_shaper_unit_tb.sv
// ----------------------------------------------------------------------------
// Phase distortion shaper testbench
// Drives phase and amount words through every shape mode, with directed corner
// values and random words, random gaps on both sides and one long output stall.
// A scoreboard predicts each warped phase and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class shaper_scoreboard;
  localparam longint unsigned ONE = 64'd65536;
  logic [2:0] mode;
  logic [15:0] pending_phase[$];
  int mismatches;
  int checked;

  function new();
    mode = pds_pkg::MODE_BEND_RIGHT;
    mismatches = 0;
    checked = 0;
  endfunction

  function longint unsigned scaled_div(longint unsigned n, longint unsigned m,
                                       longint unsigned d);
    return (n / d) * m + ((n % d) * m) / d;
  endfunction

  function longint unsigned bend_curve(longint unsigned x, longint unsigned h2);
    longint unsigned den;
    if (2 * x < h2) return scaled_div(x, ONE, h2);
    den = 2 * ONE - h2;
    if (den == 0) return ONE / 2;
    return ONE / 2 + scaled_div(2 * x - h2, ONE / 2, den);
  endfunction

  function longint unsigned warp(longint unsigned ph, longint unsigned a);
    longint unsigned r, x, lo, hi, l2, r2, mult;
    if (a > ONE) a = ONE;
    case (mode)
      pds_pkg::MODE_BEND_RIGHT: r = bend_curve(ph, ONE + a);
      pds_pkg::MODE_BEND_LEFT: r = bend_curve(ph, ONE - a);
      pds_pkg::MODE_MIRRORED: begin
        if (ph >= ONE / 2) r = ONE - bend_curve(2 * (ONE - ph), ONE - a) / 2;
        else r = bend_curve(2 * ph, ONE - a) / 2;
      end
      pds_pkg::MODE_TWO_PEAKS: begin
        x = 4 * ph;
        lo = ONE - a; hi = ONE + a; l2 = 3 * ONE - a; r2 = 3 * ONE + a;
        if (x <= lo) r = (lo == 0) ? 0 : scaled_div(x, ONE / 4, lo);
        else if (x <= hi) r = ONE / 4;
        else if (x <= l2) r = (l2 == hi) ? ONE / 4 :
                              ONE / 4 + scaled_div(x - hi, ONE / 2, l2 - hi);
        else if (x <= r2 || 4 * ONE == r2) r = 3 * (ONE / 4);
        else r = 3 * (ONE / 4) + scaled_div(x - r2, ONE / 4, 4 * ONE - r2);
      end
      pds_pkg::MODE_STRETCH: begin
        x = 2 * ph;
        lo = ONE - a; hi = ONE + a;
        if (x <= lo) r = (lo == 0) ? 0 : scaled_div(x, ONE / 2, lo);
        else if (x <= hi || 2 * ONE == hi) r = ONE / 2;
        else r = ONE / 2 + scaled_div(x - hi, ONE / 2, 2 * ONE - hi);
      end
      pds_pkg::MODE_SYNC: begin
        mult = ONE + 12 * a;
        r = (ph * (mult >> 16) + ((ph * (mult & (ONE - 1))) >> 16)) & (ONE - 1);
      end
      default: r = ph;
    endcase
    if (r > ONE - 1) r = ONE - 1;
    return r;
  endfunction

  function void note_input(logic [15:0] ph, logic [16:0] a);
    pending_phase.push_back(16'(warp(ph, a)));
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    checked++;
    if (pending_phase.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: shaped_phase=%0d", got);
      return;
    end
    want = pending_phase.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch mode %0d: shaped_phase expected %0d, got %0d", mode, want, got);
    end
  endfunction
endclass

module phase_distortion_shaper_unit_tb;
  import pds_pkg::*;

  localparam int LATENCY = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] phase_in = '0;
  logic [16:0] amount = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] shaped_phase;

  shaper_scoreboard board = new();
  int idle_cycles = 0;
  int words_sent = 0;
  bit hold_output = 0;

  phase_distortion_shaper_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .phase_in(phase_in), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready), .shaped_phase(shaped_phase)
  );

  always #10 clk = ~clk;

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_input(phase_in, amount);
      if (out_valid && out_ready) board.check_result(shaped_phase);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", board.pending_phase.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : receiver
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_output = 0;
      end else begin
        g = gap_length();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
        end
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send_word(logic [15:0] ph, logic [16:0] a);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    phase_in <= ph;
    amount <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_phase.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_mode(logic [2:0] m);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 0;
    board.mode = m;
  endtask

  function automatic logic [16:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [15:0] pick_phase();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : sender
    logic [2:0] modes[8];
    logic [15:0] ph_list[6];
    logic [16:0] a_list[4];
    modes = '{MODE_BEND_RIGHT, MODE_BEND_LEFT, MODE_MIRRORED, MODE_TWO_PEAKS,
              MODE_STRETCH, MODE_SYNC, 3'd6, 3'd7};
    ph_list = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF, 16'h5555};
    a_list = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768};
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed corners: zero, full and over-range amounts at segment edges.
    foreach (modes[m]) begin
      set_mode(modes[m]);
      for (int i = 0; i < 6; i++) send_word(ph_list[i], a_list[i % 4]);
      send_word(16'hFFFF, 17'd65536);
      send_word(16'd0, 17'd0);
      drain();
    end
    // Random phases, including one long output stall and a full pause.
    for (int blk = 0; blk < 16; blk++) begin
      set_mode(blk < 12 ? modes[blk % 6] : modes[$urandom_range(0, 7)]);
      if (blk == 3) hold_output = 1;
      for (int i = 0; i < 95; i++) send_word(pick_phase(), pick_amount());
      drain();
    end
    $display("covered %0d words over all eight mode codes, results checked: %0d",
             words_sent, board.checked);
    if (board.mismatches == 0 && board.pending_phase.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
